[rtl/lio_pkg.sv]
package lio_pkg;

  // fixed field widths
  localparam int SIDE_W    = 7;
  localparam int OUT_W     = 13;
  localparam logic [OUT_W-1:0] OUT_MAX = 13'h1FFF;
  localparam int FIRST_LABEL = 2;

  // controller states
  typedef enum logic [3:0] {
    S_LOAD,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_POP_RD,
    S_POP_GET,
    S_NB_RD,
    S_NB_CHK,
    S_W_RD,
    S_W_CHK,
    S_WN_RD,
    S_WN_LBL,
    S_WN_ADD,
    S_W_FIN,
    S_OUT
  } state_t;

  // datapath commands
  typedef enum logic [3:0] {
    OP_LOAD,
    OP_SCAN_RD,
    OP_SCAN_CHK,
    OP_POP,
    OP_CUR,
    OP_NB_RD,
    OP_NB_CHK,
    OP_W_RD,
    OP_W_CHK,
    OP_WN_RD,
    OP_WN_LBL,
    OP_WN_ADD,
    OP_W_FIN,
    OP_OUT
  } op_t;

  // datapath status towards the controller
  typedef struct packed {
    logic acc_last;
    logic scan_end;
    logic is_land;
    logic is_water;
    logic sp_zero;
    logic k_last;
    logic out_free;
  } stat_t;

endpackage

[rtl/lio_ifs.sv]
// cell request channel
interface lio_in_if;
  logic valid;
  logic ready;
  logic cell_req;
  logic last;
  modport source (output valid, output cell_req, output last, input ready);
  modport sink (input valid, input cell_req, input last, output ready);
endinterface

// result channel
interface lio_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] largest;
  modport source (output valid, output largest, input ready);
  modport sink (input valid, input largest, output ready);
endinterface

// side register write channel
interface lio_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] side;
  modport source (output valid, output side, input ready);
  modport sink (input valid, input side, output ready);
endinterface

[rtl/largest_island_one_flip.sv]
// Largest island after one flip: cells are taken one per cycle in row-major order
// until the request marked last, then a labelling walk with an explicit stack in
// on-chip memory sizes every 4-connected land component, and a second scan adds up
// the distinct neighbouring components of each water cell. No further cells are
// accepted while a grid is being solved; the result waits in an output register
// while loading of the next grid goes on. The side register is read at the last
// cell; 0 acts as 1 and values above MAX_SIDE act as MAX_SIDE, and missing cells of
// a short grid act as water.
module largest_island_one_flip #(
  parameter int MAX_SIDE = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  lio_in_if.sink    in_chan,
  lio_out_if.source out_chan,
  lio_cfg_if.sink   cfg_chan
);
  import lio_pkg::*;

  op_t   op;
  stat_t stat;

  // sequencer
  lio_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  // memories, counters and accumulators
  lio_dpath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .stat     (stat),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

endmodule

[rtl/lio_ctrl.sv]
module lio_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  lio_pkg::stat_t stat,
  output lio_pkg::op_t   op
);
  import lio_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD:     if (stat.acc_last) state_nxt = S_SCAN_RD;
      S_SCAN_RD:  state_nxt = stat.scan_end ? S_W_RD : S_SCAN_CHK;
      S_SCAN_CHK: state_nxt = stat.is_land ? S_POP_RD : S_SCAN_RD;
      S_POP_RD:   state_nxt = stat.sp_zero ? S_SCAN_RD : S_POP_GET;
      S_POP_GET:  state_nxt = S_NB_RD;
      S_NB_RD:    state_nxt = S_NB_CHK;
      S_NB_CHK:   state_nxt = stat.k_last ? S_POP_RD : S_NB_RD;
      S_W_RD:     state_nxt = stat.scan_end ? S_OUT : S_W_CHK;
      S_W_CHK:    state_nxt = stat.is_water ? S_WN_RD : S_W_RD;
      S_WN_RD:    state_nxt = S_WN_LBL;
      S_WN_LBL:   state_nxt = S_WN_ADD;
      S_WN_ADD:   state_nxt = stat.k_last ? S_W_FIN : S_WN_RD;
      S_W_FIN:    state_nxt = S_W_RD;
      S_OUT:      if (stat.out_free) state_nxt = S_LOAD;
      default:    state_nxt = S_LOAD;
    endcase
  end

  // command decode
  always_comb begin
    case (state_r)
      S_LOAD:     op = OP_LOAD;
      S_SCAN_RD:  op = OP_SCAN_RD;
      S_SCAN_CHK: op = OP_SCAN_CHK;
      S_POP_RD:   op = OP_POP;
      S_POP_GET:  op = OP_CUR;
      S_NB_RD:    op = OP_NB_RD;
      S_NB_CHK:   op = OP_NB_CHK;
      S_W_RD:     op = OP_W_RD;
      S_W_CHK:    op = OP_W_CHK;
      S_WN_RD:    op = OP_WN_RD;
      S_WN_LBL:   op = OP_WN_LBL;
      S_WN_ADD:   op = OP_WN_ADD;
      S_W_FIN:    op = OP_W_FIN;
      S_OUT:      op = OP_OUT;
      default:    op = OP_LOAD;
    endcase
  end

endmodule

[rtl/lio_dpath.sv]
module lio_dpath #(
  parameter int MAX_SIDE = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lio_pkg::op_t   op,
  output lio_pkg::stat_t stat,
  lio_in_if.sink         in_chan,
  lio_out_if.source      out_chan,
  lio_cfg_if.sink        cfg_chan
);
  import lio_pkg::*;

  localparam int CELL_CAP = MAX_SIDE * MAX_SIDE;
  localparam int AW   = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;
  localparam int PW   = AW + 1;
  localparam int SDW  = $clog2(MAX_SIDE + 1);
  localparam int SRW  = (SDW > SIDE_W) ? SDW : SIDE_W;
  localparam int CW   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int BDW  = SDW + 1;
  localparam int LCAP = CELL_CAP / 2 + 1;
  localparam int LIW  = (LCAP > 1) ? $clog2(LCAP) : 1;
  localparam int LW   = $clog2(CELL_CAP / 2 + 3);
  localparam int SW   = $clog2(CELL_CAP + 1);
  localparam int BW   = (SW + 3 > OUT_W) ? SW + 3 : OUT_W;
  localparam int STW  = AW + 2 * CW;

  // memories
  logic [LW-1:0]  lbl_mem [CELL_CAP];
  logic [STW-1:0] stk_mem [CELL_CAP];
  logic [SW-1:0]  siz_mem [LCAP];

  logic [SRW-1:0] side_r;
  logic [SDW-1:0] eff_side, s_r;
  logic [2*SDW-1:0] side_sq;
  logic [PW-1:0]  n_r, load_cnt_r, sp_r;
  logic [PW-1:0]  scan_p_r;
  logic [CW-1:0]  scan_row_r, scan_col_r;
  logic [AW-1:0]  cur_p_r;
  logic [CW-1:0]  cur_row_r, cur_col_r;
  logic [1:0]     k_r;
  logic [LW-1:0]  lab_r;
  logic [SW-1:0]  size_r;
  logic [BW-1:0]  best_r, total_r;
  logic [LW-1:0]  seen_r [4];
  logic           add_r, rd_ok_r;
  logic [LW-1:0]  lbl_q;
  logic [STW-1:0] stk_q;
  logic [SW-1:0]  siz_q;
  logic           out_vld_r;
  logic [OUT_W-1:0] out_dat_r;

  logic           acc, scan_sel, dup, add_nxt, land_val, rd_en, rd_ok_nxt;
  logic [LW-1:0]  val;
  logic [PW-1:0]  ctr_p, nb_addr, rd_addr, adv_p;
  logic [CW-1:0]  ctr_row, ctr_col, nb_row, nb_col, adv_row, adv_col;
  logic           nb_inb;
  logic [BDW-1:0] s_ext;
  logic           lbl_we;
  logic [AW-1:0]  lbl_wa;
  logic [LW-1:0]  lbl_wd;

  // side register and clamped side
  assign cfg_chan.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SRW'(MAX_SIDE);
    end else if (cfg_chan.valid) begin
      side_r <= SRW'(cfg_chan.side);
    end
  end

  always_comb begin
    if (side_r == '0) begin
      eff_side = SDW'(1);
    end else if (side_r > SRW'(MAX_SIDE)) begin
      eff_side = SDW'(MAX_SIDE);
    end else begin
      eff_side = SDW'(side_r);
    end
  end
  assign side_sq = eff_side * eff_side;

  assign in_chan.ready = (op == OP_LOAD);
  assign acc = in_chan.valid && (op == OP_LOAD);
  assign s_ext = BDW'(s_r);

  // neighbour of the walk cell or of the scanned water cell
  assign scan_sel = (op == OP_WN_RD);
  assign ctr_p   = scan_sel ? scan_p_r : PW'(cur_p_r);
  assign ctr_row = scan_sel ? scan_row_r : cur_row_r;
  assign ctr_col = scan_sel ? scan_col_r : cur_col_r;

  always_comb begin
    case (k_r)
      2'd0: begin
        nb_inb  = (BDW'(ctr_row) + BDW'(1)) < s_ext;
        nb_addr = ctr_p + PW'(s_r);
        nb_row  = ctr_row + CW'(1);
        nb_col  = ctr_col;
      end
      2'd1: begin
        nb_inb  = (BDW'(ctr_col) + BDW'(1)) < s_ext;
        nb_addr = ctr_p + PW'(1);
        nb_row  = ctr_row;
        nb_col  = ctr_col + CW'(1);
      end
      2'd2: begin
        nb_inb  = ctr_row != '0;
        nb_addr = ctr_p - PW'(s_r);
        nb_row  = ctr_row - CW'(1);
        nb_col  = ctr_col;
      end
      default: begin
        nb_inb  = ctr_col != '0;
        nb_addr = ctr_p - PW'(1);
        nb_row  = ctr_row;
        nb_col  = ctr_col - CW'(1);
      end
    endcase
  end

  // scan advance in row-major order
  always_comb begin
    adv_p = scan_p_r + PW'(1);
    if ((BDW'(scan_col_r) + BDW'(1)) == s_ext) begin
      adv_col = '0;
      adv_row = scan_row_r + CW'(1);
    end else begin
      adv_col = scan_col_r + CW'(1);
      adv_row = scan_row_r;
    end
  end

  // label read, cells never loaded read as water
  assign rd_en   = (op == OP_SCAN_RD) || (op == OP_W_RD) || (op == OP_NB_RD) ||
                   (op == OP_WN_RD);
  assign rd_addr = ((op == OP_SCAN_RD) || (op == OP_W_RD)) ? scan_p_r : nb_addr;
  assign rd_ok_nxt = (((op == OP_SCAN_RD) || (op == OP_W_RD)) ? 1'b1 : nb_inb) &&
                     (rd_addr < load_cnt_r);
  assign val      = rd_ok_r ? lbl_q : '0;
  assign land_val = (val == LW'(1));

  // duplicate neighbour label check
  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < 3; j++) begin
      if ((2'(j) < k_r) && (seen_r[j] == val)) dup = 1'b1;
    end
  end
  assign add_nxt = (val >= LW'(FIRST_LABEL)) && !dup;

  // label write port
  always_comb begin
    lbl_we = 1'b0;
    lbl_wa = scan_p_r[AW-1:0];
    lbl_wd = lab_r;
    case (op)
      OP_LOAD: begin
        lbl_we = acc && (load_cnt_r < PW'(CELL_CAP));
        lbl_wa = load_cnt_r[AW-1:0];
        lbl_wd = LW'(in_chan.cell_req);
      end
      OP_SCAN_CHK: lbl_we = land_val;
      OP_NB_CHK: begin
        lbl_we = land_val;
        lbl_wa = nb_addr[AW-1:0];
      end
      default: lbl_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (lbl_we) lbl_mem[lbl_wa] <= lbl_wd;
    if (rd_en) lbl_q <= lbl_mem[rd_addr[AW-1:0]];
  end

  // walk stack
  always_ff @(posedge clk) begin
    if ((op == OP_SCAN_CHK) && land_val) begin
      stk_mem[0] <= {scan_p_r[AW-1:0], scan_row_r, scan_col_r};
    end else if ((op == OP_NB_CHK) && land_val) begin
      stk_mem[sp_r[AW-1:0]] <= {nb_addr[AW-1:0], nb_row, nb_col};
    end
    if ((op == OP_POP) && (sp_r != '0)) begin
      stk_q <= stk_mem[sp_r[AW-1:0] - AW'(1)];
    end
  end

  // island size table, only sizes of labels handed out this grid are used
  always_ff @(posedge clk) begin
    if ((op == OP_POP) && (sp_r == '0)) begin
      siz_mem[LIW'(lab_r - LW'(FIRST_LABEL))] <= size_r;
    end
    if (op == OP_WN_LBL) begin
      siz_q <= siz_mem[LIW'(val - LW'(FIRST_LABEL))];
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if ((op == OP_OUT) && (!out_vld_r || out_chan.ready)) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
      sp_r       <= '0;
      lab_r      <= LW'(FIRST_LABEL);
      best_r     <= '0;
      rd_ok_r    <= 1'b0;
    end else begin
      if (rd_en) rd_ok_r <= rd_ok_nxt;
      case (op)
        OP_LOAD: begin
          if (acc && (load_cnt_r < PW'(CELL_CAP))) load_cnt_r <= load_cnt_r + PW'(1);
          if (acc && in_chan.last) begin
            lab_r  <= LW'(FIRST_LABEL);
            best_r <= '0;
          end
        end
        OP_SCAN_CHK: if (land_val) sp_r <= PW'(1);
        OP_POP: begin
          if (sp_r == '0) begin
            if (BW'(size_r) > best_r) best_r <= BW'(size_r);
            lab_r <= lab_r + LW'(1);
          end else begin
            sp_r <= sp_r - PW'(1);
          end
        end
        OP_NB_CHK: if (land_val) sp_r <= sp_r + PW'(1);
        OP_W_FIN: if (total_r > best_r) best_r <= total_r;
        OP_OUT: begin
          if (!out_vld_r || out_chan.ready) begin
            load_cnt_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        if (acc && in_chan.last) begin
          s_r        <= eff_side;
          n_r        <= PW'(side_sq);
          scan_p_r   <= '0;
          scan_row_r <= '0;
          scan_col_r <= '0;
        end
      end
      OP_SCAN_RD: begin
        if (scan_p_r == n_r) begin
          scan_p_r   <= '0;
          scan_row_r <= '0;
          scan_col_r <= '0;
        end
      end
      OP_SCAN_CHK: begin
        if (land_val) begin
          size_r <= '0;
        end else begin
          scan_p_r   <= adv_p;
          scan_row_r <= adv_row;
          scan_col_r <= adv_col;
        end
      end
      OP_POP: begin
        if (sp_r == '0) begin
          scan_p_r   <= adv_p;
          scan_row_r <= adv_row;
          scan_col_r <= adv_col;
        end
      end
      OP_CUR: begin
        {cur_p_r, cur_row_r, cur_col_r} <= stk_q;
        size_r <= size_r + SW'(1);
        k_r    <= '0;
      end
      OP_NB_CHK: k_r <= k_r + 2'd1;
      OP_W_CHK: begin
        if (val == '0) begin
          total_r <= BW'(1);
          k_r     <= '0;
        end else begin
          scan_p_r   <= adv_p;
          scan_row_r <= adv_row;
          scan_col_r <= adv_col;
        end
      end
      OP_WN_LBL: begin
        add_r       <= add_nxt;
        seen_r[k_r] <= val;
      end
      OP_WN_ADD: begin
        if (add_r) total_r <= total_r + BW'(siz_q);
        k_r <= k_r + 2'd1;
      end
      OP_W_FIN: begin
        scan_p_r   <= adv_p;
        scan_row_r <= adv_row;
        scan_col_r <= adv_col;
      end
      OP_OUT: begin
        if (!out_vld_r || out_chan.ready) begin
          out_dat_r <= (best_r > BW'(OUT_MAX)) ? OUT_MAX : best_r[OUT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign out_chan.valid   = out_vld_r;
  assign out_chan.largest = out_dat_r;

  // status
  assign stat.acc_last = acc && in_chan.last;
  assign stat.scan_end = (scan_p_r == n_r);
  assign stat.is_land  = land_val;
  assign stat.is_water = (val == '0);
  assign stat.sp_zero  = (sp_r == '0);
  assign stat.k_last   = (k_r == 2'd3);
  assign stat.out_free = !out_vld_r || out_chan.ready;

  // checks
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= PW'(CELL_CAP))
    else $error("walk stack pointer beyond capacity");

  a_lab_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (lab_r - LW'(FIRST_LABEL)) <= LW'(LCAP))
    else $error("label counter beyond size table");

  a_out_set: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_OUT) && (!out_vld_r || out_chan.ready) |=> out_vld_r)
    else $error("result not presented after solve");

  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_cnt_r <= PW'(CELL_CAP))
    else $error("load count beyond grid capacity");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import lio_pkg::*;

  localparam int MAX_SIDE = 64;
  localparam int CELL_CAP = MAX_SIDE * MAX_SIDE;

  // island size predictor and queue of expected sizes
  class island_scoreboard;
    logic [SIDE_W-1:0] side_reg;
    bit cells[CELL_CAP];
    int unsigned fill_pos;
    logic [OUT_W-1:0] sizes_due[$];
    int unsigned errors;

    function new();
      side_reg = SIDE_W'(MAX_SIDE);
      fill_pos = 0;
      errors = 0;
      foreach (cells[i]) cells[i] = 0;
    endfunction

    // flood every component, then try each water cell as the flip
    function logic [OUT_W-1:0] best_flip();
      int unsigned es, n, nxt, best, sp, sz, p, q, r, c, tot, cnt;
      int unsigned lab[CELL_CAP];
      int unsigned isl[CELL_CAP];
      int unsigned stk[CELL_CAP];
      int unsigned nb[4];
      bit dup;
      es = (side_reg == 0) ? 1 : (side_reg > MAX_SIDE) ? MAX_SIDE : side_reg;
      n = es * es;
      nxt = FIRST_LABEL;
      best = 0;
      for (int i = 0; i < CELL_CAP; i++) begin
        lab[i] = cells[i];
        isl[i] = 0;
      end
      for (p = 0; p < n; p++) begin
        if (lab[p] == 1) begin
          sp = 0;
          sz = 0;
          lab[p] = nxt;
          stk[sp++] = p;
          while (sp > 0) begin
            q = stk[--sp];
            r = q / es;
            c = q % es;
            sz++;
            if (r + 1 < es && lab[q + es] == 1) begin lab[q + es] = nxt; stk[sp++] = q + es; end
            if (c + 1 < es && lab[q + 1] == 1) begin lab[q + 1] = nxt; stk[sp++] = q + 1; end
            if (r > 0 && lab[q - es] == 1) begin lab[q - es] = nxt; stk[sp++] = q - es; end
            if (c > 0 && lab[q - 1] == 1) begin lab[q - 1] = nxt; stk[sp++] = q - 1; end
          end
          isl[nxt - FIRST_LABEL] = sz;
          if (sz > best) best = sz;
          nxt++;
        end
      end
      for (p = 0; p < n; p++) begin
        if (lab[p] != 0) continue;
        r = p / es;
        c = p % es;
        cnt = 0;
        tot = 1;
        if (r > 0) nb[cnt++] = lab[p - es];
        if (c > 0) nb[cnt++] = lab[p - 1];
        if (r + 1 < es) nb[cnt++] = lab[p + es];
        if (c + 1 < es) nb[cnt++] = lab[p + 1];
        for (int k = 0; k < cnt; k++) begin
          dup = 0;
          for (int j = 0; j < k; j++) if (nb[j] == nb[k]) dup = 1;
          if (!dup && nb[k] >= FIRST_LABEL) tot += isl[nb[k] - FIRST_LABEL];
        end
        if (tot > best) best = tot;
      end
      if (best > OUT_MAX) best = OUT_MAX;
      return OUT_W'(best);
    endfunction

    // store an accepted cell request, solve on the last one
    function void note_cell(bit cval, bit last);
      if (fill_pos < CELL_CAP) begin
        cells[fill_pos] = cval;
        fill_pos++;
      end
      if (last) begin
        sizes_due.push_back(best_flip());
        foreach (cells[i]) cells[i] = 0;
        fill_pos = 0;
      end
    endfunction

    function void check_size(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (sizes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0d", $time, got);
      end else begin
        want = sizes_due.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: largest mismatch, expected %0d, actual %0d", $time, want, got);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  lio_in_if  in_if ();
  lio_out_if out_if ();
  lio_cfg_if cfg_if ();

  island_scoreboard sb;
  bit calm;
  int unsigned long_hold;
  int unsigned cells_sent;

  largest_island_one_flip #(.MAX_SIDE(MAX_SIDE)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // overall time limit
  initial begin
    #200_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side with random and long stalls
  initial begin
    int unsigned stall;
    stall = 0;
    out_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) sb.check_size(out_if.largest);
      if (long_hold > 0) begin
        long_hold--;
        out_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 6);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // one cell request, with an optional idle burst before it
  task automatic send_cell(bit cval, bit last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.cell_req <= cval;
    in_if.last <= last;
    do @(posedge clk); while (!in_if.ready);
    sb.note_cell(cval, last);
    cells_sent++;
  endtask

  // a grid of count cells at the given land percentage
  task automatic send_grid(int unsigned count, int unsigned land_pct);
    for (int unsigned i = 0; i < count; i++)
      send_cell($urandom_range(0, 99) < land_pct, i == count - 1);
  endtask

  // pause until every result is back, then let the block settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.sizes_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_side(logic [SIDE_W-1:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.side <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.side_reg = v;
  endtask

  task automatic send_pattern(int unsigned s, bit chequer);
    for (int unsigned i = 0; i < s * s; i++)
      send_cell(chequer ? 1'((i / s + i % s) % 2) : 1'b1, i == s * s - 1);
  endtask

  initial begin
    int unsigned s, n;
    sb = new();
    calm = 0;
    long_hold = 0;
    cells_sent = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.cell_req = 1'b0;
    in_if.last = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.side = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short grid at the reset side
    send_grid(300, 60);
    drain();

    // single cell, land and water
    write_side(7'd1);
    send_cell(1'b1, 1'b1);
    send_cell(1'b0, 1'b1);
    drain();
    // all land, all water and chequerboard
    write_side(7'd3);
    send_pattern(3, 1'b0);
    send_grid(9, 0);
    send_pattern(3, 1'b1);
    drain();
    // side zero acts as one, short and long grids
    write_side(7'd0);
    send_grid(3, 50);
    drain();
    write_side(7'd127);
    send_grid(20, 70);
    drain();
    write_side(7'd4);
    send_grid(7, 80);
    send_grid(30, 60);
    drain();

    // random grids, mostly well formed
    while (cells_sent < 1850) begin
      case ($urandom_range(0, 9))
        0: s = $urandom_range(0, 1) ? 0 : 127;
        1: s = $urandom_range(9, 16);
        default: s = $urandom_range(1, 8);
      endcase
      write_side(SIDE_W'(s));
      if (s == 0) s = 1;
      if (s > MAX_SIDE) s = 5;
      if (cells_sent > 1500) calm = 1;
      if (!calm && $urandom_range(0, 7) == 0) long_hold = 3000;
      repeat ($urandom_range(1, 4)) begin
        n = s * s;
        case ($urandom_range(0, 9))
          0: n = $urandom_range(1, n);
          1: n = n + $urandom_range(1, 10);
          default: ;
        endcase
        send_grid(n, $urandom_range(0, 100));
      end
      drain();
    end

    while (long_hold > 0) @(posedge clk);
    drain();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
